/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// constants and field widths shared by the text console writer and its checker
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int CELL_W  = CHAR_W + ATTR_W;

    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

endpackage

/* hw/rtl/text_console_char_writer_unit.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_unit
// character-cell console: prints bytes at a cursor, scrolls, reads back cells
// ----------------------------------------------------------------------------
// A put is taken when start is high and busy is low, and its result shows on
// the next cycle with o_valid high for that one cycle; the next item can start
// in that same cycle. The receiver cannot hold a result off: each result is on
// the ports for its one o_valid cycle only. A read keeps busy high in S_READ
// because the cell store has a registered read port. A put that scrolls
// keeps busy high in S_PRE and S_SWEEP while one sweep of the store moves
// every row up and blanks the last one, one cell per cycle, and o_valid comes
// at the end of it. After reset the same sweep clears the store: busy stays
// high for the whole sweep and no result is given. The attribute register
// takes a write on any cycle and applies to later puts.
module text_console_char_writer_unit #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_mode,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0] i_cell_index,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [tcw_pkg::INDEX_W-1:0] o_cursor_cell,
    output logic                        o_scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int KEEP       = CELL_COUNT - COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = $clog2(ROWS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_PRE   = 2'd2;
    localparam logic [1:0] S_SWEEP = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [ADDR_W-1:0]  r_cnt, n_cnt;
    logic               r_clr, n_clr;
    logic [ADDR_W-1:0]  r_cursor, n_cursor;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [ATTR_W-1:0]  r_attr;
    logic               r_rd_ok, n_rd_ok;
    logic               r_valid, n_valid;
    logic [INDEX_W-1:0] r_out_cursor, n_out_cursor;
    logic               r_out_scrolled, n_out_scrolled;
    logic [CHAR_W-1:0]  r_out_char, n_out_char;
    logic [ATTR_W-1:0]  r_out_attr, n_out_attr;

    logic [CELL_W-1:0]  r_screen [CELL_COUNT];
    logic [CELL_W-1:0]  r_rd_data;

    logic               accept;
    logic               is_put;
    logic               is_nl;
    logic               col_last;
    logic               row_last;
    logic               wrap_row;
    logic               need_scroll;
    logic               idx_ok;
    logic [ADDR_W-1:0]  put_cursor;
    logic [ADDR_W:0]    ahead;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [CELL_W-1:0]  mem_wd;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_ra;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign is_put = (i_mode == MODE_PUT);
    assign is_nl  = (i_char_code == NEWLINE_CODE);

    assign col_last    = (r_col == COL_W'(COLUMNS - 1));
    assign row_last    = (r_row == ROW_W'(ROWS - 1));
    assign wrap_row    = is_nl || col_last;
    assign need_scroll = wrap_row && row_last;
    assign idx_ok      = (32'(i_cell_index) < 32'(CELL_COUNT));

    // newline jumps to the start of the next row without a divide
    always_comb begin
        if (need_scroll) begin
            put_cursor = ADDR_W'(KEEP);
        end else if (is_nl) begin
            put_cursor = r_cursor + ADDR_W'(COLUMNS) - ADDR_W'(r_col);
        end else begin
            put_cursor = r_cursor + ADDR_W'(1);
        end
    end

    // sweep reads one cell ahead of the write: cell w+COLUMNS lands at w
    assign ahead = {1'b0, r_cnt} + (ADDR_W + 1)'(COLUMNS + 1);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cursor;
        mem_wd = {r_attr, i_char_code};
        mem_re = 1'b0;
        mem_ra = ADDR_W'(i_cell_index);
        case (r_state)
            S_IDLE: begin
                if (accept && is_put && !is_nl) begin
                    mem_we = 1'b1;
                end
                if (accept && !is_put && idx_ok) begin
                    mem_re = 1'b1;
                end
            end
            S_PRE: begin
                mem_re = 1'b1;
                mem_ra = ADDR_W'(COLUMNS);
            end
            S_SWEEP: begin
                mem_we = 1'b1;
                mem_wa = r_cnt;
                mem_wd = (!r_clr && (32'(r_cnt) < 32'(KEEP))) ? r_rd_data : '0;
                mem_re = (ahead < (ADDR_W + 1)'(CELL_COUNT));
                mem_ra = ahead[ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        n_clr          = r_clr;
        n_cursor       = r_cursor;
        n_col          = r_col;
        n_row          = r_row;
        n_rd_ok        = r_rd_ok;
        n_valid        = 1'b0;
        n_out_cursor   = INDEX_W'(r_cursor);
        n_out_scrolled = 1'b0;
        n_out_char     = '0;
        n_out_attr     = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && is_put) begin
                    n_cursor     = put_cursor;
                    n_col        = wrap_row ? '0 : r_col + COL_W'(1);
                    n_row        = (wrap_row && !row_last) ? r_row + ROW_W'(1) : r_row;
                    n_out_cursor = INDEX_W'(put_cursor);
                    if (need_scroll) begin
                        n_state = S_PRE;
                    end else begin
                        n_valid = 1'b1;
                    end
                end else if (accept) begin
                    n_rd_ok = idx_ok;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_valid    = 1'b1;
                n_out_char = r_rd_ok ? r_rd_data[CHAR_W-1:0] : '0;
                n_out_attr = r_rd_ok ? r_rd_data[CELL_W-1:CHAR_W] : '0;
                n_state    = S_IDLE;
            end
            S_PRE: begin
                n_cnt   = '0;
                n_clr   = 1'b0;
                n_state = S_SWEEP;
            end
            S_SWEEP: begin
                n_cnt = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state        = S_IDLE;
                    n_valid        = !r_clr;
                    n_out_scrolled = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_cnt    <= '0;
            r_clr    <= 1'b1;
            r_cursor <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_attr   <= ATTR_RESET;
            r_rd_ok  <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_clr    <= n_clr;
            r_cursor <= n_cursor;
            r_col    <= n_col;
            r_row    <= n_row;
            r_rd_ok  <= n_rd_ok;
            r_valid  <= n_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cursor   <= n_out_cursor;
        r_out_scrolled <= n_out_scrolled;
        r_out_char     <= n_out_char;
        r_out_attr     <= n_out_attr;
    end

    // cell store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_screen[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_screen[mem_ra];
        end
    end

    assign o_valid       = r_valid;
    assign o_cursor_cell = r_out_cursor;
    assign o_scrolled    = r_out_scrolled;
    assign o_cell_char   = r_out_char;
    assign o_cell_attr   = r_out_attr;

endmodule

/* hw/rtl/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// port-level checks on the console writer's result timing and scroll results
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_mode,
    input logic                        o_valid,
    input logic [tcw_pkg::INDEX_W-1:0] o_cursor_cell,
    input logic                        o_scrolled,
    input logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    input logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr
);
    import tcw_pkg::*;

    localparam logic [INDEX_W-1:0] SCROLL_CURSOR = INDEX_W'((ROWS - 1) * COLUMNS);

    logic rd_go;
    logic put_go;
    logic scroll_ok;

    assign rd_go     = start && !busy && (i_mode == MODE_READ);
    assign put_go    = start && !busy && (i_mode == MODE_PUT);
    assign scroll_ok = (o_cursor_cell == SCROLL_CURSOR) && (o_cell_char == '0)
                       && (o_cell_attr == '0);

    // a read transfer makes the unit busy and then returns its cell, never as a scroll
    `AST_NEXT(a_read_latency, rd_go, busy ##1 (o_valid && !o_scrolled), "read result late")

    // a put either finishes at once or goes into the scroll sweep
    `AST_NEXT(a_put_progress, put_go, o_valid || busy, "put neither finished nor scrolling")

    // a scroll leaves the cursor at the start of the last row and returns a zero cell
    `AST_IMPL(a_scroll_result, o_valid && o_scrolled, scroll_ok, "bad scroll result")

    // results only come out when the unit is free again
    `AST_IMPL(a_valid_idle, o_valid, !busy, "result while busy")

endmodule

bind text_console_char_writer_unit tcw_checker #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_mode       (i_mode),
    .o_valid      (o_valid),
    .o_cursor_cell(o_cursor_cell),
    .o_scrolled   (o_scrolled),
    .o_cell_char  (o_cell_char),
    .o_cell_attr  (o_cell_attr)
);

/* tb/text_console_char_writer_unit_tb.sv */
// ----------------------------------------------------------------------------
// text_console_char_writer_unit_tb
// self-checking bench: puts, newlines and cell reads against a screen mirror
// ----------------------------------------------------------------------------
module text_console_char_writer_unit_tb;
    import tcw_pkg::*;

    localparam int COLS  = DEF_COLUMNS;
    localparam int ROWS  = DEF_ROWS;
    localparam int CELLS = COLS * ROWS;
    localparam int CYCLE_LIMIT  = 10_000_000;
    localparam int PHASE_ITEMS  = 265;
    localparam int PHASE_COUNT  = 6;
    localparam int SETTLE_TICKS = 20;

    typedef struct packed {
        logic [INDEX_W-1:0] cursor_cell;
        logic               scrolled;
        logic [CHAR_W-1:0]  cell_char;
        logic [ATTR_W-1:0]  cell_attr;
    } t_console_result;

    // mirror of the screen store, cursor and attribute; queues one result per transfer
    class t_screen_mirror;
        logic [CELL_W-1:0] cells [0:CELLS-1];
        int                cursor_pos;
        logic [ATTR_W-1:0] attr;
        t_console_result   pending_results [$];
        int errors, puts, newlines, reads, far_reads, scrolls, attr_writes;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cursor_pos = 0;
            attr = ATTR_RESET;
        endfunction

        function void set_attribute(logic [ATTR_W-1:0] value);
            attr = value;
            attr_writes++;
        endfunction

        function void take_item(logic mode, logic [CHAR_W-1:0] ch,
                                logic [INDEX_W-1:0] idx);
            t_console_result want;
            want = '0;
            if (mode == MODE_PUT) begin
                puts++;
                if (cursor_pos >= CELLS) cursor_pos = 0;
                if (ch == NEWLINE_CODE) begin
                    newlines++;
                    cursor_pos = (cursor_pos / COLS + 1) * COLS;
                end else begin
                    cells[cursor_pos] = {attr, ch};
                    cursor_pos++;
                end
                if (cursor_pos >= CELLS) begin
                    // every row moves up one, last row comes back blank
                    for (int i = 0; i < CELLS - COLS; i++) cells[i] = cells[i + COLS];
                    for (int i = CELLS - COLS; i < CELLS; i++) cells[i] = '0;
                    cursor_pos = CELLS - COLS;
                    want.scrolled = 1'b1;
                    scrolls++;
                end
            end else begin
                reads++;
                if (idx < CELLS) begin
                    want.cell_char = cells[idx][CHAR_W-1:0];
                    want.cell_attr = cells[idx][CELL_W-1:CHAR_W];
                end else begin
                    far_reads++;
                end
            end
            want.cursor_cell = cursor_pos[INDEX_W-1:0];
            pending_results.push_back(want);
        endfunction

        function void check_result(t_console_result got);
            t_console_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $error("result with no transfer outstanding: cursor_cell %0d",
                       got.cursor_cell);
                return;
            end
            want = pending_results.pop_front();
            if (got.cursor_cell !== want.cursor_cell) begin
                errors++;
                $error("cursor_cell: expected %0d, actual %0d",
                       want.cursor_cell, got.cursor_cell);
            end
            if (got.scrolled !== want.scrolled) begin
                errors++;
                $error("scrolled: expected %0d, actual %0d", want.scrolled, got.scrolled);
            end
            if (got.cell_char !== want.cell_char) begin
                errors++;
                $error("cell_char: expected 0x%02h, actual 0x%02h",
                       want.cell_char, got.cell_char);
            end
            if (got.cell_attr !== want.cell_attr) begin
                errors++;
                $error("cell_attr: expected 0x%02h, actual 0x%02h",
                       want.cell_attr, got.cell_attr);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_mode = MODE_PUT;
    logic [CHAR_W-1:0]  i_char_code = '0;
    logic [INDEX_W-1:0] i_cell_index = '0;
    logic               i_cfg_we = 1'b0;
    logic [ATTR_W-1:0]  i_cfg_wdata = '0;
    logic               o_valid;
    logic [INDEX_W-1:0] o_cursor_cell;
    logic               o_scrolled;
    logic [CHAR_W-1:0]  o_cell_char;
    logic [ATTR_W-1:0]  o_cell_attr;

    t_screen_mirror sb;
    int unsigned    cycle_count = 0;

    text_console_char_writer_unit #(
        .COLUMNS(COLS),
        .ROWS   (ROWS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_valid      (o_valid),
        .o_cursor_cell(o_cursor_cell),
        .o_scrolled   (o_scrolled),
        .o_cell_char  (o_cell_char),
        .o_cell_attr  (o_cell_attr)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_result({o_cursor_cell, o_scrolled, o_cell_char, o_cell_attr});
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // call right after posedge i_clk; start stays high when no gap follows
    task automatic send_item(input logic mode, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx, input int gap);
        start        <= 1'b1;
        i_mode       <= mode;
        i_char_code  <= ch;
        i_cell_index <= idx;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.take_item(mode, ch, idx);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_attribute(value);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_random(input int newline_pct, input bit with_gaps);
        int                 r;
        int                 gap;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = INDEX_W'($urandom_range(0, 2047));
        gap = with_gaps ? pick_gap() : 0;
        if (r < newline_pct) begin
            send_item(MODE_PUT, NEWLINE_CODE, idx, gap);
        end else if (r < 70) begin
            send_item(MODE_PUT, ch, idx, gap);
        end else if (r < 85) begin
            // read back something written lately, up to three rows behind the cursor
            idx = INDEX_W'((sb.cursor_pos + CELLS - $urandom_range(1, 3 * COLS)) % CELLS);
            send_item(MODE_READ, ch, idx, gap);
        end else if (r < 96) begin
            send_item(MODE_READ, ch, INDEX_W'($urandom_range(0, CELLS - 1)), gap);
        end else begin
            send_item(MODE_READ, ch, INDEX_W'($urandom_range(CELLS, 2047)), gap);
        end
    endtask

    initial begin
        logic [ATTR_W-1:0] phase_attr [PHASE_COUNT];
        int                phase_newline [PHASE_COUNT];
        bit                phase_gaps [PHASE_COUNT];

        sb = new();
        phase_attr    = '{8'h00, 8'hff, 8'h00, 8'h80, 8'h01, 8'h00};
        phase_attr[2] = ATTR_W'($urandom_range(0, 255));
        phase_attr[5] = ATTR_W'($urandom_range(0, 255));
        phase_newline = '{15, 15, 10, 3, 20, 12};
        phase_gaps    = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, with the attribute still at its reset value
        send_item(MODE_PUT, 8'h00, 11'h7ff, 0);
        send_item(MODE_PUT, 8'hff, 11'h000, 0);
        send_item(MODE_READ, 8'hff, 11'd0, 0);
        send_item(MODE_READ, 8'h00, 11'd1, 0);
        send_item(MODE_READ, 8'h00, 11'(CELLS - 1), 0);
        send_item(MODE_READ, 8'h00, 11'(CELLS), 0);
        send_item(MODE_READ, 8'h00, 11'h7ff, 0);
        // walk to the last row by newlines; the last one scrolls
        repeat (ROWS) send_item(MODE_PUT, NEWLINE_CODE, 11'h000, 0);
        send_item(MODE_READ, 8'h00, 11'd1, 0);
        drain();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_attribute(phase_attr[p]);
            repeat (PHASE_ITEMS) send_random(phase_newline[p], phase_gaps[p]);
            drain();
        end

        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("covered %0d puts (%0d newlines) and %0d reads (%0d out of range)",
                 sb.puts, sb.newlines, sb.reads, sb.far_reads);
        $display("screen scrolled %0d times over %0d attribute settings",
                 sb.scrolls, sb.attr_writes + 1);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
